// ===== rtl/core/utf8_validate_count_top_defines.svh =====
// Assertion macros for the UTF-8 validator block.
// Both use the local clk and rst_n of the asserting module.
`ifndef UTF8_VALIDATE_COUNT_TOP_DEFINES_SVH
`define UTF8_VALIDATE_COUNT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define UVC_ASSERT_NOW(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("utf8 validator check failed");

`define UVC_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("utf8 validator check failed");

`else

`define UVC_ASSERT_NOW(label, a, c)

`define UVC_ASSERT_NEXT(label, a, c)

`endif

`endif

// ===== rtl/core/utf8vc_pkg.sv =====
package utf8vc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int PART_BITS  = 21;
    localparam int OUT_BITS   = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [31:0]           OUT_MAX   = 32'h0000_ffff;

    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] ASCII_MIN = 8'h01;
    localparam logic [7:0] ASCII_MAX = 8'h7f;
    localparam logic [7:0] LEAD2_MIN = 8'hc2;
    localparam logic [7:0] LEAD2_MAX = 8'hdf;
    localparam logic [7:0] LEAD3_MIN = 8'he0;
    localparam logic [7:0] LEAD3_MAX = 8'hef;
    localparam logic [7:0] LEAD4_MIN = 8'hf0;
    localparam logic [7:0] LEAD4_MAX = 8'hf4;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    localparam logic [PART_BITS-1:0] MIN_CP2    = 21'h00080;
    localparam logic [PART_BITS-1:0] MIN_CP3    = 21'h00800;
    localparam logic [PART_BITS-1:0] MIN_CP4    = 21'h10000;
    localparam logic [PART_BITS-1:0] SURR_LO    = 21'h0d800;
    localparam logic [PART_BITS-1:0] SURR_HI    = 21'h0dfff;
    localparam logic [PART_BITS-1:0] MAX_CP     = 21'h10ffff;

    typedef struct packed {
        logic [1:0]            pending;
        logic [2:0]            seq_len;
        logic [PART_BITS-1:0]  partial;
        logic                  err;
        logic [COUNT_BITS-1:0] count;
    } scan_state_t;

    typedef struct packed {
        logic                is_valid;
        logic [OUT_BITS-1:0] point_count;
    } scan_result_t;

endpackage

// ===== rtl/core/utf8vc_decode.sv =====
module utf8vc_decode
    import utf8vc_pkg::*;
(
    input  scan_state_t  cur,
    input  logic [7:0]   data_byte,
    input  logic         is_final,
    output scan_state_t  nxt,
    output scan_result_t res
);

    logic [PART_BITS-1:0] cp;
    logic [31:0]          cnt_wide;
    logic                 end_err;

    function automatic logic point_ok(input logic [2:0] len, input logic [PART_BITS-1:0] p);
        logic ok;
        begin
            ok = (p != '0);
            if (len == SEQ_LEN2 && p < MIN_CP2) ok = 1'b0;
            if (len == SEQ_LEN3 && p < MIN_CP3) ok = 1'b0;
            if (len == SEQ_LEN4 && p < MIN_CP4) ok = 1'b0;
            if (p >= SURR_LO && p <= SURR_HI) ok = 1'b0;
            if (p > MAX_CP) ok = 1'b0;
            return ok;
        end
    endfunction

    assign cp = {cur.partial[PART_BITS-7:0], data_byte[5:0]};

    always_comb
    begin
        nxt      = cur;
        res      = '0;
        cnt_wide = '0;
        end_err  = 1'b0;
        if (!cur.err)
        begin
            if (cur.pending == 2'd0)
            begin
                unique case (data_byte) inside
                    NUL_BYTE:
                    begin
                        nxt.err = 1'b1;
                    end
                    [ASCII_MIN:ASCII_MAX]:
                    begin
                        if (cur.count != COUNT_MAX) nxt.count = cur.count + 1'b1;
                    end
                    [LEAD2_MIN:LEAD2_MAX]:
                    begin
                        nxt.seq_len = SEQ_LEN2;
                        nxt.pending = 2'd1;
                        nxt.partial = PART_BITS'(data_byte[4:0]);
                    end
                    [LEAD3_MIN:LEAD3_MAX]:
                    begin
                        nxt.seq_len = SEQ_LEN3;
                        nxt.pending = 2'd2;
                        nxt.partial = PART_BITS'(data_byte[3:0]);
                    end
                    [LEAD4_MIN:LEAD4_MAX]:
                    begin
                        nxt.seq_len = SEQ_LEN4;
                        nxt.pending = 2'd3;
                        nxt.partial = PART_BITS'(data_byte[2:0]);
                    end
                    default:
                    begin
                        nxt.err = 1'b1;
                    end
                endcase
            end
            else if (data_byte[7:6] != CONT_TAG)
            begin
                nxt.err = 1'b1;
            end
            else
            begin
                nxt.partial = cp;
                nxt.pending = cur.pending - 2'd1;
                if (cur.pending == 2'd1)
                begin
                    if (point_ok(cur.seq_len, cp))
                    begin
                        if (cur.count != COUNT_MAX) nxt.count = cur.count + 1'b1;
                    end
                    else
                    begin
                        nxt.err = 1'b1;
                    end
                    nxt.seq_len = '0;
                    nxt.partial = '0;
                end
            end
        end
        if (is_final)
        begin
            end_err  = nxt.err || (nxt.pending != 2'd0);
            cnt_wide = 32'(nxt.count);
            res.is_valid = !end_err;
            if (!end_err)
                res.point_count = (cnt_wide > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0]
                                                       : cnt_wide[OUT_BITS-1:0];
            nxt = '0;
        end
    end

endmodule

// ===== rtl/core/utf8_validate_count_top.sv =====
// Streaming strict UTF-8 validator and code point counter. Bytes of a string
// arrive one item per cycle on s_axis, tlast marking the final byte; one
// result item leaves on m_axis for each string, carrying the saturating point
// count in tdata and the well-formed flag in tuser (count is zero when the flag
// is low). Sustained rate is one byte per cycle via the single combinational
// decode stage between the input register and the state/result registers; a
// result shows once its final byte moves from input to result register. A
// stalled result holds off only the next final byte, other bytes keep flowing.
`include "utf8_validate_count_top_defines.svh"

module utf8_validate_count_top
    import utf8vc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tlast,   // is_final
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_BITS-1:0] m_axis_tdata,   // [15:0] point_count
    output logic                m_axis_tuser    // [0] is_valid
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    scan_state_t  state_reg, state_next;
    scan_result_t res_reg, res_comb;
    logic         out_valid_reg, out_valid_next;
    logic         s_fire;
    logic         stage_fire;

    assign stage_fire    = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || stage_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    utf8vc_decode u_decode (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .is_final  (in_last_reg),
        .nxt       (state_next),
        .res       (res_comb)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (stage_fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (stage_fire && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (stage_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (stage_fire && in_last_reg)
            res_reg <= res_comb;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg.point_count;
    assign m_axis_tuser  = res_reg.is_valid;

    `UVC_ASSERT_NEXT(a_final_gives_result, stage_fire && in_last_reg, m_axis_tvalid)
    `UVC_ASSERT_NEXT(a_final_clears_state, stage_fire && in_last_reg,
                     state_reg.count == '0 && !state_reg.err && state_reg.pending == 2'd0)
    `UVC_ASSERT_NOW(a_pending_below_len, state_reg.pending != 2'd0,
                    3'(state_reg.pending) < state_reg.seq_len)

endmodule

// ===== tb/sv/utf8_validate_count_top_tb.sv =====
module utf8_validate_count_top_tb;
    import utf8vc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PHASE_BYTES = 352;

    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         has_exp;
        scan_result_t exp;
    } byte_item_t;

    // data, last, typed expectation?, {is_valid, point_count}
    localparam byte_item_t DIR_ROWS [0:25] = '{
        '{8'h41, 1'b1, 1'b1, '{1'b1, 16'd1}},
        '{8'h00, 1'b1, 1'b1, '{1'b0, 16'd0}},
        '{8'hff, 1'b1, 1'b1, '{1'b0, 16'd0}},
        '{8'hc1, 1'b1, 1'b1, '{1'b0, 16'd0}},
        '{8'h80, 1'b1, 1'b1, '{1'b0, 16'd0}},
        '{8'hc2, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h80, 1'b1, 1'b0, '{1'b0, 16'd0}},
        '{8'hed, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'ha0, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h80, 1'b1, 1'b1, '{1'b0, 16'd0}},
        '{8'hf4, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h8f, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'hbf, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'hbf, 1'b1, 1'b0, '{1'b0, 16'd0}},
        '{8'hf4, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h90, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h80, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h80, 1'b1, 1'b1, '{1'b0, 16'd0}},
        '{8'he0, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h9f, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'hbf, 1'b1, 1'b1, '{1'b0, 16'd0}},
        '{8'hc2, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h41, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h7f, 1'b1, 1'b1, '{1'b0, 16'd0}},
        '{8'he1, 1'b0, 1'b0, '{1'b0, 16'd0}},
        '{8'h80, 1'b1, 1'b1, '{1'b0, 16'd0}}
    };

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    // predictor state
    logic [1:0]            cont_left;
    logic [2:0]            seq_len;
    logic [PART_BITS-1:0]  partial_cp;
    logic                  str_err;
    logic [COUNT_BITS-1:0] pt_count;

    byte_item_t   stim_q [$];
    scan_result_t string_results [$];
    logic [7:0]   str_bytes [$];
    byte_item_t   cur_item;

    bit          in_fire;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned stall_cycles;
    int unsigned fail_count;

    utf8_validate_count_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_scan();
        cont_left  = '0;
        seq_len    = '0;
        partial_cp = '0;
        str_err    = 1'b0;
        pt_count   = '0;
    endfunction

    function automatic void bump_points();
        if (pt_count != COUNT_MAX)
            pt_count = pt_count + 1'b1;
    endfunction

    function automatic bit point_legal(input logic [2:0] len, input logic [PART_BITS-1:0] cp);
        if (len == SEQ_LEN2 && cp < MIN_CP2)
            return 1'b0;
        if (len == SEQ_LEN3 && cp < MIN_CP3)
            return 1'b0;
        if (len == SEQ_LEN4 && cp < MIN_CP4)
            return 1'b0;
        if (cp >= SURR_LO && cp <= SURR_HI)
            return 1'b0;
        if (cp > MAX_CP)
            return 1'b0;
        return cp != '0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        if (str_err)
            return;
        if (cont_left == 2'd0)
        begin
            if (b <= ASCII_MAX)
            begin
                if (b == NUL_BYTE)
                    str_err = 1'b1;
                else
                    bump_points();
            end
            else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
            begin
                seq_len    = SEQ_LEN2;
                cont_left  = 2'd1;
                partial_cp = PART_BITS'(b[4:0]);
            end
            else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
            begin
                seq_len    = SEQ_LEN3;
                cont_left  = 2'd2;
                partial_cp = PART_BITS'(b[3:0]);
            end
            else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
            begin
                seq_len    = SEQ_LEN4;
                cont_left  = 2'd3;
                partial_cp = PART_BITS'(b[2:0]);
            end
            else
                str_err = 1'b1;
            return;
        end
        if (b[7:6] != CONT_TAG)
        begin
            str_err = 1'b1;
            return;
        end
        partial_cp = {partial_cp[PART_BITS-7:0], b[5:0]};
        cont_left  = cont_left - 2'd1;
        if (cont_left == 2'd0)
        begin
            if (point_legal(seq_len, partial_cp))
                bump_points();
            else
                str_err = 1'b1;
            seq_len    = '0;
            partial_cp = '0;
        end
    endfunction

    function automatic scan_result_t close_string();
        scan_result_t r;
        if (cont_left != 2'd0)
            str_err = 1'b1;
        r.is_valid = !str_err;
        if (str_err)
            r.point_count = '0;
        else if (32'(pt_count) > OUT_MAX)
            r.point_count = OUT_MAX[OUT_BITS-1:0];
        else
            r.point_count = OUT_BITS'(pt_count);
        clear_scan();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        scan_result_t want;
        scan_result_t got_pred;
        bit out_fire;
        out_fire = rst_n && ((m_axis_tvalid && m_axis_tready) === 1'b1);
        in_fire  = rst_n && ((s_axis_tvalid && s_axis_tready) === 1'b1);
        if (out_fire)
        begin
            if (string_results.size() == 0)
                report_mismatch("result with nothing expected", 32'(m_axis_tdata), 32'd0);
            else
            begin
                want = string_results.pop_front();
                if (m_axis_tuser !== want.is_valid)
                    report_mismatch("is_valid", 32'(m_axis_tuser), 32'(want.is_valid));
                if (m_axis_tdata !== want.point_count)
                    report_mismatch("point_count", 32'(m_axis_tdata), 32'(want.point_count));
            end
        end
        if (in_fire)
        begin
            absorb_byte(cur_item.data);
            if (cur_item.last)
            begin
                got_pred = close_string();
                string_results.push_back(cur_item.has_exp ? cur_item.exp : got_pred);
            end
        end
        if (!rst_n || in_fire || out_fire)
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    initial
    begin
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        while (1'b1)
        begin
            @(negedge clk);
            if (s_axis_tvalid && !in_fire)
                continue;
            if (stim_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                break;
            end
            if ($urandom_range(0, 99) < src_idle_pct)
                s_axis_tvalid <= 1'b0;
            else
            begin
                cur_item = stim_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= cur_item.data;
                s_axis_tlast  <= cur_item.last;
            end
        end
    endtask

    function automatic int unsigned pick_in(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    function automatic int unsigned good_cp(input int unsigned len);
        int unsigned cp;
        case (len)
            1: cp = pick_in(32'h1, 32'h7f);
            2: cp = pick_in(32'h80, 32'h7ff);
            3:
            begin
                cp = pick_in(32'h800, 32'hffff);
                if (cp >= 32'hd800 && cp <= 32'hdfff)
                    cp = cp - 32'h800;
            end
            default: cp = pick_in(32'h10000, 32'h10ffff);
        endcase
        return cp;
    endfunction

    function automatic void put_point(input logic [20:0] cp, input int unsigned len);
        case (len)
            1: str_bytes.push_back({1'b0, cp[6:0]});
            2:
            begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // returns 1 when the string has to end here (cut-off sequence)
    function automatic bit put_bad();
        int unsigned kind;
        int unsigned len;
        int unsigned pos;
        logic [7:0] b;
        kind = $urandom_range(0, 6);
        len  = $urandom_range(2, 4);
        case (kind)
            0: put_point(21'($urandom_range(0, 32'h7ff)), 3);
            1: put_point(21'($urandom_range(0, 32'hffff)), 4);
            2: put_point(21'($urandom_range(32'hd800, 32'hdfff)), 3);
            3: put_point(21'($urandom_range(32'h110000, 32'h13ffff)), 4);
            4:
            begin
                case ($urandom_range(0, 2))
                    0: str_bytes.push_back(NUL_BYTE);
                    1: str_bytes.push_back(8'($urandom_range(8'h80, 8'hc1)));
                    default: str_bytes.push_back(8'($urandom_range(8'hf5, 8'hff)));
                endcase
            end
            5:
            begin
                put_point(21'(good_cp(len)), len);
                b = 8'($urandom);
                while (b[7:6] == CONT_TAG)
                    b = 8'($urandom);
                pos = str_bytes.size() - len + $urandom_range(1, len - 1);
                str_bytes[pos] = b;
            end
            default:
            begin
                put_point(21'(good_cp(len)), len);
                repeat ($urandom_range(1, len - 1))
                    void'(str_bytes.pop_back());
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic int unsigned emit_string();
        int unsigned npts;
        int unsigned mode;
        int unsigned bad_at;
        int unsigned plen;
        byte_item_t it;
        str_bytes.delete();
        mode = $urandom_range(0, 99);
        npts = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        if (mode < 10)
        begin
            repeat (npts)
                str_bytes.push_back(8'($urandom));
        end
        else
        begin
            bad_at = (mode < 65) ? npts : $urandom_range(0, npts - 1);
            for (int i = 0; i < npts; i++)
            begin
                if (i == bad_at)
                begin
                    if (put_bad())
                        break;
                end
                else
                begin
                    plen = $urandom_range(1, 4);
                    put_point(21'(good_cp(plen)), plen);
                end
            end
        end
        foreach (str_bytes[i])
        begin
            it.data    = str_bytes[i];
            it.last    = (i == str_bytes.size() - 1);
            it.has_exp = 1'b0;
            it.exp     = '0;
            stim_q.push_back(it);
        end
        return str_bytes.size();
    endfunction

    initial
    begin
        int unsigned phase_bytes;
        int unsigned src_pct [4];
        int unsigned snk_pct [4];
        src_pct = '{0, 84, 0, 20};
        snk_pct = '{0, 0, 84, 20};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        fail_count    = 0;
        in_fire       = 1'b0;
        cur_item      = '0;
        clear_scan();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIR_ROWS[i])
            stim_q.push_back(DIR_ROWS[i]);
        run_phase(0, 0);

        for (int p = 0; p < 4; p++)
        begin
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                phase_bytes += emit_string();
            run_phase(src_pct[p], snk_pct[p]);
        end

        while (string_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
